/* hdl/idl_pkg.sv */
// Shared constants, types and codes for the int8 dense layer.
package idl_pkg;

   localparam int MAX_INPUTS  = 256;
   localparam int MAX_OUTPUTS = 32;
   localparam int MAC_LANES   = 8;

   localparam int FUNC_W    = 2;
   localparam int ROW_W     = 5;
   localparam int COL_W     = 8;
   localparam int VAL_W     = 8;
   localparam int NEURON_W  = 5;
   localparam int RES_W     = 16;
   localparam int AIN_W     = 9;
   localparam int AOUT_W    = 6;
   localparam int CSR_W     = 9;
   localparam int CSR_IDX_W = 1;

   localparam int OUT_AW     = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
   localparam int IN_AW      = $clog2(MAX_INPUTS);
   localparam int N_GRP      = MAX_INPUTS / MAC_LANES;
   localparam int GRP_AW     = (N_GRP > 1) ? $clog2(N_GRP) : 1;
   localparam int WMEM_DEPTH = MAX_OUTPUTS * N_GRP;
   localparam int WMEM_AW    = OUT_AW + GRP_AW;
   localparam int ROWC_W     = $clog2(MAX_OUTPUTS + 1);
   localparam int GRPC_W     = $clog2(N_GRP + 1);
   localparam int NIN_W      = $clog2(MAX_INPUTS + 1);

   localparam int CQ_DEPTH = 4;
   localparam int CQ_AW    = $clog2(CQ_DEPTH);
   localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);
   localparam int OQ_DEPTH = 4;
   localparam int OQ_AW    = $clog2(OQ_DEPTH);
   localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_INPUTS  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_OUTPUTS = 1'b1;

   localparam logic [AIN_W-1:0]  AIN_RESET  = AIN_W'(256);
   localparam logic [AOUT_W-1:0] AOUT_RESET = AOUT_W'(32);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_WEIGHT = 2'd0,
      FUNC_BIAS   = 2'd1,
      FUNC_ACT    = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_RUN  = 1'b1
   } bk_state_type;

   typedef struct packed {
      logic              wr_weight;
      logic              wr_bias;
      logic              wr_act;
      logic              start;
      logic [OUT_AW-1:0] row;
      logic [IN_AW-1:0]  col;
      logic [VAL_W-1:0]  value;
   } cmd_type;

   typedef struct packed {
      logic                 valid;
      logic                 first;
      logic                 last_grp;
      logic                 last_row;
      logic [OUT_AW-1:0]    row;
      logic [MAC_LANES-1:0] mask;
   } mac_ctl_type;

   typedef struct packed {
      logic [NEURON_W-1:0] neuron;
      logic [RES_W-1:0]    value;
      logic                last;
   } rsp_type;

endpackage

/* hdl/int8_dense_layer.sv */
// Top level of the int8 dense layer: front end, back end and result queue.
//
//   Channel | Direction | Handshake         | Word
//   req     | in        | req_valid/stall   | func, row, col, value, last
//   rsp     | out       | rsp_valid/stall   | neuron, result_value, last_result
//   csr     | in        | csr_wen           | csr_index, csr_wdata
//
// Weight, bias and activation words are taken one per cycle while the command queue has room.
// A run covers active_outputs * max(1, ceil(active_inputs / 8)) groups in the eight-lane MAC,
// one weight group per cycle while no row start is held back by the result queue.
// Synchronous reset clears the queues and sequencer, presets the configuration, leaves the stores.
// A stalled result queue holds back the start of new rows; during a run the front end keeps
// taking words until its four-entry command queue is full.
module int8_dense_layer import idl_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [FUNC_W-1:0]       req_func,
   input  logic [ROW_W-1:0]        req_row,
   input  logic [COL_W-1:0]        req_col,
   input  logic signed [VAL_W-1:0] req_value,
   input  logic                    req_last,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [NEURON_W-1:0]     rsp_neuron,
   output logic signed [RES_W-1:0] rsp_result_value,
   output logic                    rsp_last_result,
   input  logic                    csr_wen,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_W-1:0]        csr_wdata
);

   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;
   logic    res_push;
   rsp_type res_data;
   rsp_type rsp_data;
   logic    rsp_pop;

   idl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_func  (req_func),
      .req_row   (req_row),
      .req_col   (req_col),
      .req_value (req_value),
      .req_last  (req_last),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   idl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .res_push  (res_push),
      .res_data  (res_data),
      .rsp_pop   (rsp_pop)
   );

   idl_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .rsp_pop   (rsp_pop)
   );

   assign rsp_neuron       = rsp_data.neuron;
   assign rsp_result_value = rsp_data.value;
   assign rsp_last_result  = rsp_data.last;

endmodule

/* hdl/idl_front.sv */
// Front end: accepts request words, decodes them and queues commands for the back end.
module idl_front import idl_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [FUNC_W-1:0]       req_func,
   input  logic [ROW_W-1:0]        req_row,
   input  logic [COL_W-1:0]        req_col,
   input  logic signed [VAL_W-1:0] req_value,
   input  logic                    req_last,
   output logic                    cmd_valid,
   output cmd_type                 cmd,
   input  logic                    cmd_pop
);

   cmd_type          cq_ff [CQ_DEPTH];
   logic [CQ_AW-1:0] wptr_ff, wptr_in;
   logic [CQ_AW-1:0] rptr_ff, rptr_in;
   logic [CQ_CW-1:0] cnt_ff, cnt_in;
   cmd_type          cmd_in;
   logic             row_ok;
   logic             col_ok;
   logic             useful;
   logic             push;

   always_comb begin
      row_ok = int'(req_row) < MAX_OUTPUTS;
      col_ok = int'(req_col) < MAX_INPUTS;
      cmd_in = '0;
      cmd_in.row   = OUT_AW'(req_row);
      cmd_in.col   = IN_AW'(req_col);
      cmd_in.value = req_value;
      case (func_type'(req_func))
         FUNC_WEIGHT: begin
            cmd_in.wr_weight = row_ok && col_ok;
         end
         FUNC_BIAS: begin
            cmd_in.wr_bias = row_ok;
         end
         FUNC_ACT: begin
            cmd_in.wr_act = col_ok;
            cmd_in.start  = req_last;
         end
         default: begin
            cmd_in.wr_weight = 1'b0;
         end
      endcase
      useful = cmd_in.wr_weight || cmd_in.wr_bias || cmd_in.wr_act || cmd_in.start;
   end

   assign req_stall = (cnt_ff == CQ_CW'(CQ_DEPTH));
   assign push      = req_valid && !req_stall && useful;
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = cq_ff[rptr_ff];

   always_comb begin
      wptr_in = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = cmd_pop ? rptr_ff + 1'b1 : rptr_ff;
      cnt_in  = cnt_ff + CQ_CW'(push) - CQ_CW'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         cq_ff[wptr_ff] <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

/* hdl/idl_outq.sv */
// Result queue that holds finished rows until the consumer takes them.
module idl_outq import idl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data,
   output logic    rsp_pop
);

   rsp_type          oq_ff [OQ_DEPTH];
   logic [OQ_AW-1:0] wptr_ff, wptr_in;
   logic [OQ_AW-1:0] rptr_ff, rptr_in;
   logic [OQ_CW-1:0] cnt_ff, cnt_in;

   assign rsp_valid = (cnt_ff != '0);
   assign rsp_data  = oq_ff[rptr_ff];
   assign rsp_pop   = rsp_valid && !rsp_stall;

   always_comb begin
      wptr_in = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = rsp_pop ? rptr_ff + 1'b1 : rptr_ff;
      cnt_in  = cnt_ff + OQ_CW'(push) - OQ_CW'(rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         oq_ff[wptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

/* hdl/idl_back.sv */
// Back end: configuration, weight/bias/activation stores, row sequencer and MAC pipeline.
module idl_back import idl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wen,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   input  logic                 cmd_valid,
   input  cmd_type              cmd,
   output logic                 cmd_pop,
   output logic                 res_push,
   output rsp_type              res_data,
   input  logic                 rsp_pop
);

   logic [AIN_W-1:0]  ain_ff;
   logic [AOUT_W-1:0] aout_ff;

   bk_state_type state_ff, state_in;

   logic [ROWC_W-1:0] row_ff, row_in;
   logic [GRPC_W-1:0] grp_ff, grp_in;
   logic [NIN_W-1:0]  nin_ff, nin_in;
   logic [GRPC_W-1:0] ngrp_ff, ngrp_in;
   logic [ROWC_W-1:0] nout_ff, nout_in;
   logic [OQ_CW-1:0]  pending_ff, pending_in;

   logic [NIN_W-1:0]  nin_sat;
   logic [NIN_W:0]    nin_round;
   logic [GRPC_W-1:0] ngrp_calc;
   logic [ROWC_W-1:0] nout_sat;

   logic run_start;
   logic issue;
   logic last_grp;
   logic last_row;
   logic wr_weight;
   logic wr_bias;
   logic wr_act;

   logic [WMEM_AW-1:0] w_waddr;
   logic [WMEM_AW-1:0] w_raddr;
   logic [GRP_AW-1:0]  cmd_grp;

   mac_ctl_type issue_ctl;
   mac_ctl_type s1_ctl_ff;
   mac_ctl_type s2_ctl_ff;
   mac_ctl_type s3_ctl_ff;

   logic signed [VAL_W-1:0] wrd_ff [MAC_LANES];
   logic signed [VAL_W-1:0] ard_ff [MAC_LANES];
   logic signed [VAL_W-1:0] brd_ff;
   logic signed [VAL_W-1:0] s2_bias_ff;
   logic signed [VAL_W-1:0] s3_bias_ff;
   logic signed [RES_W-1:0] prod_ff [MAC_LANES];
   logic signed [RES_W-1:0] prod_in [MAC_LANES];
   logic [RES_W-1:0]        psum_ff [2];
   logic [RES_W-1:0]        psum_in [2];
   logic [RES_W-1:0]        acc_ff, acc_in;

   logic signed [VAL_W-1:0] b_mem [MAX_OUTPUTS];

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ain_ff  <= AIN_RESET;
         aout_ff <= AOUT_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_ACTIVE_INPUTS: begin
               ain_ff <= AIN_W'(csr_wdata);
            end
            CSR_ACTIVE_OUTPUTS: begin
               aout_ff <= AOUT_W'(csr_wdata);
            end
            default: begin
               ain_ff <= ain_ff;
            end
         endcase
      end
   end

   // Counts saturated to the store sizes; an empty dot product still takes one group.
   always_comb begin
      nin_sat   = (int'(ain_ff) > MAX_INPUTS) ? NIN_W'(MAX_INPUTS) : NIN_W'(ain_ff);
      nout_sat  = (int'(aout_ff) > MAX_OUTPUTS) ? ROWC_W'(MAX_OUTPUTS) : ROWC_W'(aout_ff);
      nin_round = {1'b0, nin_sat} + (NIN_W+1)'(MAC_LANES - 1);
      ngrp_calc = GRPC_W'(nin_round / MAC_LANES);
      if (ngrp_calc == '0) begin
         ngrp_calc = GRPC_W'(1);
      end
   end

   assign last_grp = (grp_ff == GRPC_W'(ngrp_ff - 1'b1));
   assign last_row = (row_ff == ROWC_W'(nout_ff - 1'b1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && cmd.start && nout_sat != '0) begin
               state_in = BK_RUN;
            end
         end
         BK_RUN: begin
            if (issue && last_grp && last_row) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      cmd_pop = 1'b0;
      issue   = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            cmd_pop = cmd_valid;
         end
         BK_RUN: begin
            issue = (grp_ff != '0) || (pending_ff < OQ_CW'(OQ_DEPTH));
         end
         default: begin
            cmd_pop = 1'b0;
         end
      endcase
   end

   assign run_start = cmd_pop && cmd.start;
   assign wr_weight = cmd_pop && cmd.wr_weight;
   assign wr_bias   = cmd_pop && cmd.wr_bias;
   assign wr_act    = cmd_pop && cmd.wr_act;

   always_comb begin
      row_in  = row_ff;
      grp_in  = grp_ff;
      nin_in  = nin_ff;
      ngrp_in = ngrp_ff;
      nout_in = nout_ff;
      if (run_start) begin
         row_in  = '0;
         grp_in  = '0;
         nin_in  = nin_sat;
         ngrp_in = ngrp_calc;
         nout_in = nout_sat;
      end else if (issue) begin
         if (last_grp) begin
            grp_in = '0;
            row_in = row_ff + 1'b1;
         end else begin
            grp_in = grp_ff + 1'b1;
         end
      end
      pending_in = pending_ff + OQ_CW'(issue && grp_ff == '0) - OQ_CW'(rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_IDLE;
         row_ff     <= '0;
         grp_ff     <= '0;
         nin_ff     <= '0;
         ngrp_ff    <= GRPC_W'(1);
         nout_ff    <= '0;
         pending_ff <= '0;
      end else begin
         state_ff   <= state_in;
         row_ff     <= row_in;
         grp_ff     <= grp_in;
         nin_ff     <= nin_in;
         ngrp_ff    <= ngrp_in;
         nout_ff    <= nout_in;
         pending_ff <= pending_in;
      end
   end

   // Issue control: lanes past the active input count contribute nothing.
   always_comb begin
      issue_ctl          = '0;
      issue_ctl.valid    = issue;
      issue_ctl.first    = (grp_ff == '0);
      issue_ctl.last_grp = last_grp;
      issue_ctl.last_row = last_row;
      issue_ctl.row      = row_ff[OUT_AW-1:0];
      for (int l = 0; l < MAC_LANES; l++) begin
         issue_ctl.mask[l] = (int'(grp_ff) * MAC_LANES + l) < int'(nin_ff);
      end
   end

   assign cmd_grp = GRP_AW'(cmd.col / MAC_LANES);
   assign w_waddr = {cmd.row, cmd_grp};
   assign w_raddr = {row_ff[OUT_AW-1:0], grp_ff[GRP_AW-1:0]};

   // One weight bank and one activation bank per lane, read a whole group at a time.
   for (genvar l = 0; l < MAC_LANES; l++) begin : g_lane
      logic signed [VAL_W-1:0] w_mem [WMEM_DEPTH];
      logic signed [VAL_W-1:0] a_mem [N_GRP];
      logic                    lane_hit;

      assign lane_hit = (int'(cmd.col % MAC_LANES) == l);

      always_ff @(posedge clock) begin
         if (wr_weight && lane_hit) begin
            w_mem[w_waddr] <= cmd.value;
         end
         wrd_ff[l] <= w_mem[w_raddr];
      end

      always_ff @(posedge clock) begin
         if (wr_act && lane_hit) begin
            a_mem[cmd_grp] <= cmd.value;
         end
         ard_ff[l] <= a_mem[grp_ff[GRP_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_bias) begin
         b_mem[cmd.row] <= cmd.value;
      end
      brd_ff <= b_mem[row_ff[OUT_AW-1:0]];
   end

   // Multiply, reduce into even- and odd-lane partial sums, accumulate.
   always_comb begin
      for (int l = 0; l < MAC_LANES; l++) begin
         prod_in[l] = s1_ctl_ff.mask[l] ? RES_W'(wrd_ff[l]) * RES_W'(ard_ff[l]) : '0;
      end
      psum_in[0] = '0;
      psum_in[1] = '0;
      for (int l = 0; l < MAC_LANES; l++) begin
         psum_in[l % 2] = psum_in[l % 2] + prod_ff[l];
      end
      acc_in = (s3_ctl_ff.first ? RES_W'(s3_bias_ff) : acc_ff) + psum_ff[0] + psum_ff[1];
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < MAC_LANES; l++) begin
         prod_ff[l] <= prod_in[l];
      end
      psum_ff[0] <= psum_in[0];
      psum_ff[1] <= psum_in[1];
      s2_bias_ff <= brd_ff;
      s3_bias_ff <= s2_bias_ff;
      if (s3_ctl_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         s3_ctl_ff <= '0;
      end else begin
         s1_ctl_ff <= issue_ctl;
         s2_ctl_ff <= s1_ctl_ff;
         s3_ctl_ff <= s2_ctl_ff;
      end
   end

   assign res_push        = s3_ctl_ff.valid && s3_ctl_ff.last_grp;
   assign res_data.neuron = NEURON_W'(s3_ctl_ff.row);
   assign res_data.value  = acc_in;
   assign res_data.last   = s3_ctl_ff.last_row;

endmodule

/* hdl/idl_checker.sv */
// Port-level checks for the int8 dense layer and their binding to the top level.
module idl_checker import idl_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [NEURON_W-1:0]     rsp_neuron,
   input logic signed [RES_W-1:0] rsp_result_value,
   input logic                    rsp_last_result
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_neuron)
         && $stable(rsp_result_value) && $stable(rsp_last_result))
      else $error("stalled result word changed");

   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word offered right after reset");

   a_req_reset: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("request channel stalled right after reset");

   a_top_row_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_neuron == NEURON_W'(MAX_OUTPUTS - 1) |-> rsp_last_result)
      else $error("highest row emitted without last flag");

endmodule

bind int8_dense_layer idl_checker u_idl_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_neuron       (rsp_neuron),
   .rsp_result_value (rsp_result_value),
   .rsp_last_result  (rsp_last_result)
);
